@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sci assertion failed");
`define SCI_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("sci forbidden condition");
`else
`define SCI_ASSERT(lbl, clk, rst, prop)
`define SCI_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ rtl/sci_pkg.sv @@
// ----------------------------------------------------------------------------
// sci_pkg
// Shared types and constants of the sky coefficient interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package sci_pkg;

  localparam int SKY_PARAMS  = 9;
  localparam int CTRL_POINTS = 6;

  localparam int WORD_W  = 32;
  localparam int ANGLE_W = 18;
  localparam int TURB_W  = 16;
  localparam int ALB_W   = 17;
  localparam int TK_W    = 13;
  localparam int KW      = 17;

  localparam logic [ANGLE_W-1:0] HALF_PI_Q16 = 18'd102944;
  localparam logic [ALB_W-1:0]   ONE_Q16     = 17'd65536;
  localparam logic [3:0]         PS_RADIANCE = 4'd9;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

  typedef enum logic {
    CFG_TURBIDITY = 1'b0,
    CFG_ALBEDO    = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic          done;
    logic [KW-1:0] k;
  } elev_rsp_t;

endpackage

`default_nettype wire

@@ rtl/sci_ram.sv @@
// ----------------------------------------------------------------------------
// sci_ram
// Coefficient table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_ram #(
  parameter int DEPTH = 3600,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [sci_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [sci_pkg::WORD_W-1:0] rdata
);
  import sci_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/sci_elev.sv @@
// ----------------------------------------------------------------------------
// sci_elev
// Elevation term k = cbrt(1 - theta/(pi/2)): bitwise cube root search; each
// trial bit is squared, cubed and compared in turn. The ratio is never formed: each trial cube is scaled by
// pi/2 and compared with (pi/2 - theta) * 2^48.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_elev (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sci_pkg::ANGLE_W-1:0] sun_angle,
  output sci_pkg::elev_rsp_t          rsp
);
  import sci_pkg::*;

  localparam int QW  = 48;
  localparam int CW  = 3 * KW;
  localparam int SW  = CW + ANGLE_W;
  localparam int BPW = $clog2(KW);

  typedef enum logic [1:0] {S_IDLE, S_SQ, S_CUBE, S_CMP} state_t;

  state_t             state;
  logic [ANGLE_W-1:0] dreg;
  logic [BPW-1:0]     bitpos;
  logic [KW-1:0]      root;
  logic [KW-1:0]      trial;
  logic [2*KW-1:0]    sq;
  logic [CW-1:0]      cube;
  logic               done;

  logic [ANGLE_W-1:0] d;
  logic [KW-1:0]      trial_c;
  logic [SW-1:0]      cube_x, scaled, target;

  // below the horizon the ratio is zero, so the search ends at k = 0
  assign d = (sun_angle >= HALF_PI_Q16) ? '0 : (HALF_PI_Q16 - sun_angle);

  assign trial_c = root | (KW'(1) << bitpos);

  // pi/2 in Q2.16 is 2^16 + 2^15 + 2^12 + 2^9 + 2^5
  assign cube_x = SW'(cube);
  assign scaled = (cube_x << 16) + (cube_x << 15) + (cube_x << 12) +
                  (cube_x << 9) + (cube_x << 5);
  assign target = SW'(dreg) << QW;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      bitpos <= '0;
      root   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            dreg   <= d;
            root   <= '0;
            bitpos <= BPW'(KW - 1);
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          trial <= trial_c;
          sq    <= (2*KW)'(trial_c) * (2*KW)'(trial_c);
          state <= S_CUBE;
        end
        S_CUBE: begin
          cube  <= CW'(sq) * CW'(trial);
          state <= S_CMP;
        end
        S_CMP: begin
          if (scaled <= target) begin
            root <= trial;
          end
          if (bitpos == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            bitpos <= bitpos - BPW'(1);
            state  <= S_SQ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.k    = root;

endmodule

`default_nettype wire

@@ rtl/sci_eval.sv @@
// ----------------------------------------------------------------------------
// sci_eval
// Evaluate sequencer: reads four spline control sets from the table, runs
// de Casteljau on a shared multiplier, then the albedo and turbidity blends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sci_eval #(
  parameter int TURBIDITY_LEVELS = 10,
  parameter int AW               = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 channel,
  input  logic [3:0]                 param_select,
  input  logic [sci_pkg::TURB_W-1:0] turbidity,
  input  logic [sci_pkg::ALB_W-1:0]  albedo,
  input  sci_pkg::elev_rsp_t         elev,
  output logic [AW-1:0]              rd_addr,
  input  logic [sci_pkg::WORD_W-1:0] rd_data,
  output logic                       busy,
  output logic                       done,
  output logic [sci_pkg::WORD_W-1:0] coefficient
);
  import sci_pkg::*;

  localparam int TL  = TURBIDITY_LEVELS;
  localparam int CHW = (SKY_PARAMS + 1) * CTRL_POINTS * TL * 2;
  localparam int PW  = SKY_PARAMS * CTRL_POINTS * TL * 2;
  localparam int TLW = $clog2(TL + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT_K, S_SETUP, S_READ, S_LERP, S_BLEND0, S_BLEND1, S_BLEND2
  } state_t;

  state_t                   state;
  logic [KW-1:0]            kreg;
  logic [1:0]               spl;
  logic [2:0]               cnt;
  logic [2:0]               lvl;
  logic [2:0]               step;
  logic [AW-1:0]            addr;
  logic [AW-1:0]            base;
  logic [AW-1:0]            off0, off1, half;
  logic [3:0]               strd;
  logic [TK_W-1:0]          tk;
  logic [ALB_W-1:0]         alb;
  logic signed [WORD_W-1:0] p [CTRL_POINTS];
  logic signed [WORD_W-1:0] s [4];
  logic signed [WORD_W-1:0] v0, v1;

  // setup decode
  logic                     is_sky;
  logic [AW-1:0]            ch_base, base_c;
  logic [4:0]               ti;
  logic [TLW-1:0]           t0, t1;
  logic [17:0]              tkd;
  logic [TK_W-1:0]          tk_c;
  logic [ALB_W-1:0]         alb_c;
  logic [5:0]               blk;
  logic [AW-1:0]            sp_start;

  // shared multiply-round-add
  logic signed [34:0]       mx;
  logic signed [17:0]       my;
  logic signed [52:0]       prod, biased, shifted;
  logic signed [WORD_W-1:0] mbase;
  logic                     use_q12;
  logic signed [WORD_W-1:0] mres;

  always_comb begin
    is_sky  = (param_select != PS_RADIANCE);
    ch_base = AW'(channel) * AW'(CHW);
    base_c  = is_sky ? (ch_base + AW'(param_select)) : (ch_base + AW'(PW));
    blk     = is_sky ? 6'(SKY_PARAMS * CTRL_POINTS) : 6'(CTRL_POINTS);

    ti = {1'b0, turbidity[TURB_W-1:12]};
    if (ti == 5'd0) begin
      t0 = TLW'(1);
    end else if (ti > 5'(TL)) begin
      t0 = TLW'(TL);
    end else begin
      t0 = TLW'(ti);
    end
    t1 = (t0 == TLW'(TL)) ? t0 : (t0 + TLW'(1));

    tkd = 18'(turbidity) - (18'(t0) << 12);
    if (tkd[17]) begin
      tk_c = '0;
    end else if (tkd > 18'd4096) begin
      tk_c = TK_W'(4096);
    end else begin
      tk_c = tkd[TK_W-1:0];
    end
    alb_c = (albedo > ONE_Q16) ? ONE_Q16 : albedo;
  end

  // spline order: albedo 0 / 1 at level t0, then albedo 0 / 1 at level t1
  assign sp_start = base + (spl[0] ? half : '0) + (spl[1] ? off1 : off0);

  always_comb begin
    mx      = 35'(p[1]) - 35'(p[0]);
    my      = $signed({1'b0, kreg});
    mbase   = p[0];
    use_q12 = 1'b0;
    case (state)
      S_BLEND0: begin
        mx    = 35'(s[1]) - 35'(s[0]);
        my    = $signed(18'(alb));
        mbase = s[0];
      end
      S_BLEND1: begin
        mx    = 35'(s[3]) - 35'(s[2]);
        my    = $signed(18'(alb));
        mbase = s[2];
      end
      S_BLEND2: begin
        mx      = 35'(v1) - 35'(v0);
        my      = $signed(18'(tk));
        mbase   = v0;
        use_q12 = 1'b1;
      end
      default: ;
    endcase
    prod    = mx * my;
    biased  = prod + (use_q12 ? 53'sd2048 : 53'sd32768);
    shifted = use_q12 ? (biased >>> 12) : (biased >>> 16);
    // a*(1-w) + b*w == a + (b-a)*w; convex, so the sum stays in 32 bits
    mres    = WORD_W'(shifted + 53'(mbase));
  end

  assign rd_addr = addr;
  assign busy    = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      spl   <= '0;
      cnt   <= '0;
      lvl   <= '0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            base  <= base_c;
            strd  <= is_sky ? 4'(SKY_PARAMS) : 4'd1;
            off0  <= AW'(blk) * AW'(t0 - TLW'(1));
            off1  <= AW'(blk) * AW'(t1 - TLW'(1));
            half  <= AW'(blk) * AW'(TL);
            tk    <= tk_c;
            alb   <= alb_c;
            state <= S_WAIT_K;
          end
        end
        S_WAIT_K: begin
          if (elev.done) begin
            kreg  <= elev.k;
            spl   <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          addr  <= sp_start;
          cnt   <= '0;
          state <= S_READ;
        end
        S_READ: begin
          if (cnt < 3'(CTRL_POINTS)) begin
            addr <= addr + AW'(strd);
          end
          // read data arrives in the cycle after its address
          if (cnt != '0) begin
            for (int j = 0; j < CTRL_POINTS - 1; j++) begin
              p[j] <= p[j+1];
            end
            p[CTRL_POINTS-1] <= rd_data;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'(CTRL_POINTS)) begin
            lvl   <= 3'(CTRL_POINTS);
            step  <= '0;
            state <= S_LERP;
          end
        end
        S_LERP: begin
          // rotate the active points left, new point lands at the end
          for (int j = 0; j < CTRL_POINTS - 1; j++) begin
            if (3'(j) == lvl - 3'd1) begin
              p[j] <= mres;
            end else begin
              p[j] <= p[j+1];
            end
          end
          if (lvl == 3'(CTRL_POINTS)) begin
            p[CTRL_POINTS-1] <= mres;
          end
          if (step == lvl - 3'd1) begin
            step <= '0;
            lvl  <= lvl - 3'd1;
            if (lvl == 3'd2) begin
              s[spl] <= p[1];
              spl    <= spl + 2'd1;
              state  <= (spl == 2'd3) ? S_BLEND0 : S_SETUP;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        S_BLEND0: begin
          v0    <= mres;
          state <= S_BLEND1;
        end
        S_BLEND1: begin
          v1    <= mres;
          state <= S_BLEND2;
        end
        S_BLEND2: begin
          coefficient <= mres;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SCI_ASSERT(a_done_after_blend, clk, rst, done |-> $past(state == S_BLEND2))
  `SCI_ASSERT(a_lvl_range, clk, rst, (state == S_LERP) |-> (lvl >= 3'd2 && lvl <= 3'(CTRL_POINTS)))
  `SCI_NEVER(a_elev_unexpected, clk, rst, elev.done && state != S_WAIT_K)

endmodule

`default_nettype wire

@@ rtl/sky_coefficient_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// sky_coefficient_interpolator_top
// Sky model coefficient table with spline evaluation at the sun elevation.
//
// channel   signals                                   direction
// request   start/busy, action, channel, table_offset,  in
//           table_word, param_select, sun_angle
// result    done, coefficient, channel_out, param_out   out
// config    cfg_valid/cfg_ready, cfg_index, cfg_data    in
//
// A table write leaves busy low.
// An evaluate holds busy while it runs the cube root search for k, takes
// k, makes four spline passes on the single table read port, and then
// runs the albedo and turbidity blends.
// Result is on the outputs for one cycle with done; it cannot be stalled.
// Synchronous reset; the table itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sky_coefficient_interpolator_top #(
  parameter int CHANNELS         = 3,
  parameter int TURBIDITY_LEVELS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [1:0]                  channel,
  input  logic [10:0]                 table_offset,
  input  logic [sci_pkg::WORD_W-1:0]  table_word,
  input  logic [3:0]                  param_select,
  input  logic [sci_pkg::ANGLE_W-1:0] sun_angle,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [sci_pkg::ALB_W-1:0]   cfg_data,
  output logic                        done,
  output logic [sci_pkg::WORD_W-1:0]  coefficient,
  output logic [1:0]                  channel_out,
  output logic [3:0]                  param_out
);
  import sci_pkg::*;

  localparam int CHW   = (SKY_PARAMS + 1) * CTRL_POINTS * TURBIDITY_LEVELS * 2;
  localparam int DEPTH = CHANNELS * CHW;
  localparam int AW    = $clog2(DEPTH);

  logic [TURB_W-1:0] turbidity;
  logic [ALB_W-1:0]  albedo;
  logic              accept, ch_ok, wr_en, eval_start;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] rdata;
  elev_rsp_t         elev;

  assign accept     = start && !busy;
  assign ch_ok      = (int'(channel) < CHANNELS);
  assign wr_en      = accept && (action == ACT_WRITE) && ch_ok && (int'(table_offset) < CHW);
  assign eval_start = accept && (action == ACT_EVAL) && ch_ok && (param_select <= PS_RADIANCE);
  assign waddr      = AW'(channel) * AW'(CHW) + AW'(table_offset);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      turbidity <= TURB_W'(16384);
      albedo    <= ALB_W'(6554);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TURBIDITY: turbidity <= cfg_data[TURB_W-1:0];
        CFG_ALBEDO:    albedo    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (eval_start) begin
      channel_out <= channel;
      param_out   <= param_select;
    end
  end

  sci_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (table_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  sci_elev u_elev (
    .clk       (clk),
    .rst       (rst),
    .start     (eval_start),
    .sun_angle (sun_angle),
    .rsp       (elev)
  );

  sci_eval #(
    .TURBIDITY_LEVELS (TURBIDITY_LEVELS),
    .AW               (AW)
  ) u_eval (
    .clk          (clk),
    .rst          (rst),
    .start        (eval_start),
    .channel      (channel),
    .param_select (param_select),
    .turbidity    (turbidity),
    .albedo       (albedo),
    .elev         (elev),
    .rd_addr      (raddr),
    .rd_data      (rdata),
    .busy         (busy),
    .done         (done),
    .coefficient  (coefficient)
  );

endmodule

`default_nettype wire

@@ tb/sv/sky_coefficient_interpolator_top_test.sv @@
// ----------------------------------------------------------------------------
// sky_coefficient_interpolator_top_test
// Loads one full spline set per channel, then runs table writes and
// evaluations under several turbidity/albedo settings. Each evaluation is
// predicted in the bench and compared field by field against the block's result.
// ----------------------------------------------------------------------------
`default_nettype none

module sky_coefficient_interpolator_top_test;
  import sci_pkg::*;

  localparam int NCH        = 3;
  localparam int LEVELS     = 10;
  localparam int PARAM_WDS  = SKY_PARAMS * CTRL_POINTS * LEVELS * 2;
  localparam int CH_WDS     = PARAM_WDS + CTRL_POINTS * LEVELS * 2;
  localparam int TBL_DEPTH  = NCH * CH_WDS;
  localparam int MAX_CYCLES = 3000000;
  localparam int SETTLE     = 250;

  typedef struct {
    action_t     act;
    logic [1:0]  ch;
    logic [10:0] off;
    logic [31:0] word;
    logic [3:0]  ps;
    logic [17:0] ang;
  } sky_req_t;

  typedef struct {
    logic [31:0] coeff;
    logic [1:0]  ch;
    logic [3:0]  ps;
  } coeff_rsp_t;

  logic clk, rst;
  logic start, busy, action, cfg_valid, cfg_ready, done;
  logic [1:0]  channel, channel_out;
  logic [10:0] table_offset;
  logic [31:0] table_word, coefficient;
  logic [3:0]  param_select, param_out;
  logic [17:0] sun_angle;
  logic [0:0]  cfg_index;
  logic [16:0] cfg_data;

  sky_coefficient_interpolator_top dut (.*);

  sky_req_t   req_q[$];
  coeff_rsp_t coeff_q[$];
  logic [31:0] shadow_tbl[TBL_DEPTH];
  bit          written[TBL_DEPTH];
  logic [15:0] turb_reg;
  logic [16:0] alb_reg;
  int cycles, mismatches, n_writes, n_evals, n_checked, gap;
  bit taken, burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint elev_k(logic [17:0] ang);
    longint unsigned d, q, r, x, kk, trial;
    kk = 0;
    if (ang >= HALF_PI_Q16) return 0;
    d = HALF_PI_Q16 - ang;
    q = (d << 31) / HALF_PI_Q16;
    r = (d << 31) % HALF_PI_Q16;
    x = (q << 17) + ((r << 17) / HALF_PI_Q16);
    for (int b = 16; b >= 0; b--) begin
      trial = kk | (64'd1 << b);
      if (trial * trial * trial <= x) kk = trial;
    end
    return longint'(kk);
  endfunction

  function automatic longint bezier_at(int base, int stride, longint kk);
    longint p[CTRL_POINTS];
    for (int i = 0; i < CTRL_POINTS; i++)
      p[i] = longint'($signed(shadow_tbl[base + stride * i]));
    for (int lvl = CTRL_POINTS - 1; lvl > 0; lvl--)
      for (int i = 0; i < lvl; i++)
        p[i] = rnd_shift(p[i] * (65536 - kk) + p[i + 1] * kk, 16);
    return p[0];
  endfunction

  function automatic logic [31:0] sky_coeff(int ch, int ps, logic [17:0] ang);
    int base, stride, half, ti, t0, t1;
    longint kk, a, tk, s00, s10, s01, s11, v0, v1, res;
    if (ps < SKY_PARAMS) begin
      base = ch * CH_WDS + ps;
      stride = SKY_PARAMS;
    end else begin
      base = ch * CH_WDS + PARAM_WDS;
      stride = 1;
    end
    half = stride * CTRL_POINTS * LEVELS;
    kk = elev_k(ang);
    ti = turb_reg >> 12;
    t0 = ti < 1 ? 1 : (ti > LEVELS ? LEVELS : ti);
    t1 = t0 + 1 > LEVELS ? LEVELS : t0 + 1;
    tk = longint'(turb_reg) - t0 * 4096;
    if (tk < 0) tk = 0;
    if (tk > 4096) tk = 4096;
    a = alb_reg > 65536 ? 65536 : longint'(alb_reg);
    s00 = bezier_at(base + stride * CTRL_POINTS * (t0 - 1), stride, kk);
    s10 = bezier_at(base + half + stride * CTRL_POINTS * (t0 - 1), stride, kk);
    s01 = bezier_at(base + stride * CTRL_POINTS * (t1 - 1), stride, kk);
    s11 = bezier_at(base + half + stride * CTRL_POINTS * (t1 - 1), stride, kk);
    v0 = rnd_shift(s00 * (65536 - a) + s10 * a, 16);
    v1 = rnd_shift(s01 * (65536 - a) + s11 * a, 16);
    res = rnd_shift(v0 * (4096 - tk) + v1 * tk, 12);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // true when every word the evaluation reads has been queued for writing
  function automatic bit eval_ready(int ch, int ps);
    int base, stride;
    if (ch >= NCH || ps > SKY_PARAMS) return 1'b1;
    base   = (ps < SKY_PARAMS) ? ch * CH_WDS + ps : ch * CH_WDS + PARAM_WDS;
    stride = (ps < SKY_PARAMS) ? SKY_PARAMS : 1;
    for (int i = 0; i < CTRL_POINTS * LEVELS * 2; i++)
      if (!written[base + stride * i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic add_write(int ch, int off, logic [31:0] w);
    sky_req_t r;
    r = '{ACT_WRITE, ch[1:0], off[10:0], w, 4'($urandom), 18'($urandom)};
    if (ch < NCH && off < CH_WDS) written[ch * CH_WDS + off] = 1'b1;
    req_q.push_back(r);
  endtask

  task automatic add_eval(int ch, int ps, logic [17:0] ang);
    sky_req_t r;
    if (!eval_ready(ch, ps)) begin
      // fall back to one of the spline sets loaded up front
      ch = $urandom_range(0, NCH - 1);
      ps = (ch == 0) ? 0 : ((ch == 1) ? PS_RADIANCE : 4);
    end
    r = '{ACT_EVAL, ch[1:0], 11'($urandom), $urandom, ps[3:0], ang};
    req_q.push_back(r);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [17:0] rnd_angle();
    case ($urandom_range(0, 9))
      0: return 18'd0;
      1: return HALF_PI_Q16 - 18'd1;
      2: return HALF_PI_Q16;
      3: return 18'h3FFFF;
      4: return 18'($urandom_range(102944, 262143));
      default: return 18'($urandom_range(0, 102943));
    endcase
  endfunction

  task automatic random_requests(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 30)
        add_write($urandom_range(0, NCH - 1), $urandom_range(0, CH_WDS - 1), rnd_word());
      else if (sel < 34)
        add_write($urandom_range(0, 3), $urandom_range(CH_WDS, 2047), rnd_word());
      else if (sel < 37)
        add_write(3, $urandom_range(0, 2047), rnd_word());
      else if (sel < 41)
        add_eval($urandom_range(0, 1) ? 3 : $urandom_range(0, NCH - 1),
                 $urandom_range(10, 15), rnd_angle());
      else
        add_eval($urandom_range(0, NCH - 1), $urandom_range(0, 9), rnd_angle());
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (req_q.size() != 0 || start || coeff_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_index_t idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TURBIDITY) turb_reg = val[15:0];
    else alb_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !taken) begin
        // hold current request
      end else if (gap > 0) begin
        start <= 1'b0;
        gap--;
      end else if (req_q.size() != 0) begin
        sky_req_t r;
        r = req_q.pop_front();
        start        <= 1'b1;
        action       <= r.act;
        channel      <= r.ch;
        table_offset <= r.off;
        table_word   <= r.word;
        param_select <= r.ps;
        sun_angle    <= r.ang;
        if ($urandom_range(0, 39) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 4);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
    taken = start && !busy && !rst;
    if (!rst && done) begin
      if (coeff_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result coeff=%h", coefficient);
      end else begin
        coeff_rsp_t e;
        e = coeff_q.pop_front();
        n_checked++;
        if (coefficient !== e.coeff || channel_out !== e.ch || param_out !== e.ps) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp coeff=%h ch=%0d ps=%0d got coeff=%h ch=%0d ps=%0d",
                     e.coeff, e.ch, e.ps, coefficient, channel_out, param_out);
        end
      end
    end
    if (taken) begin
      if (action == ACT_WRITE) begin
        n_writes++;
        if (channel < NCH && table_offset < CH_WDS)
          shadow_tbl[channel * CH_WDS + table_offset] = table_word;
      end else if (channel < NCH && param_select <= PS_RADIANCE) begin
        n_evals++;
        coeff_q.push_back('{sky_coeff(channel, param_select, sun_angle),
                            channel, param_select});
      end
    end
  end

  initial begin
    logic [15:0] turb_set[6];
    logic [16:0] alb_set[6];
    rst = 1'b1;
    start = 1'b0; action = ACT_WRITE; channel = '0; table_offset = '0;
    table_word = '0; param_select = '0; sun_angle = '0;
    cfg_valid = 1'b0; cfg_index = CFG_TURBIDITY; cfg_data = '0;
    cycles = 0; mismatches = 0; n_writes = 0; n_evals = 0; n_checked = 0;
    gap = 0; taken = 1'b0; burst = 1'b0;
    turb_reg = 16'd16384;
    alb_reg  = 17'd6554;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one complete spline set per channel; evaluations only read words
    // that were written before them
    for (int i = 0; i < CTRL_POINTS * LEVELS * 2; i++) begin
      add_write(0, SKY_PARAMS * i, rnd_word());
      add_write(1, PARAM_WDS + i, rnd_word());
      add_write(2, 4 + SKY_PARAMS * i, rnd_word());
    end

    // directed: table extremes, horizon cases, ignored requests
    add_write(0, 0, 32'h8000_0000);
    add_write(2, CH_WDS - 1, 32'h7FFF_FFFF);
    add_write(1, CH_WDS, 32'hDEAD_BEEF);
    add_write(3, 5, 32'h1234_5678);
    add_write(2, 2047, 32'hFFFF_FFFF);
    add_eval(0, 0, 18'd0);
    add_eval(0, 0, HALF_PI_Q16 - 18'd1);
    add_eval(1, 9, HALF_PI_Q16);
    add_eval(1, 9, 18'h3FFFF);
    add_eval(2, 4, 18'd51472);
    add_eval(2, 4, 18'd1);
    add_eval(3, 0, 18'd100);
    add_eval(0, 10, 18'd100);
    add_eval(1, 15, 18'd100);
    add_eval(1, 9, 18'd0);
    random_requests(107);
    wait_idle();

    turb_set = '{16'd0, 16'd40960, 16'd65535, 16'd4096, 16'd38912, 16'd0};
    alb_set  = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd0, 17'd0};
    turb_set[5] = 16'($urandom);
    alb_set[5]  = 17'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_TURBIDITY, {1'b0, turb_set[ph]});
      cfg_write(CFG_ALBEDO, alb_set[ph]);
      random_requests(103);
      wait_idle();
    end

    $display("%0d writes and %0d evaluations, %0d results checked, %0d mismatches",
             n_writes, n_evals, n_checked, mismatches);
    $display("seven turbidity/albedo settings including both ends of each register");
    if (mismatches == 0 && coeff_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
